// File: src/sm_pkg.sv
package sm_pkg;

  // Q30 datapath width, with headroom for CORDIC gain and negation
  localparam int CW          = 34;
  localparam int STEPS       = 30;
  localparam int OUT_W       = 19;
  localparam int OPAC_W      = 20;
  localparam int RW          = 72;
  localparam logic [OPAC_W-1:0] OPAC_RESET = 20'd6554;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  // 3/(8*pi) in Q24
  localparam logic signed [22:0] PREF_Q24 = 23'sd2002633;

  // arctangent of 2^-i in 2^-32 turn units
  localparam logic [31:0] ATAN [STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  // sine/cosine of all four angles, handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] sti;
    logic signed [CW-1:0] cti;
    logic signed [CW-1:0] spi;
    logic signed [CW-1:0] cpi;
    logic signed [CW-1:0] sto;
    logic signed [CW-1:0] cto;
    logic signed [CW-1:0] spo;
    logic signed [CW-1:0] cpo;
  } trig_t;

  // round half up: add half, then floor shift
  function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] v,
                                               input int s);
    logic signed [RW-1:0] h;
    h = RW'(1) <<< (s - 1);
    return (v + h) >>> s;
  endfunction

endpackage

// File: src/sm_if.sv
interface sm_in_if #(parameter int AW = 16);
  logic          valid;
  logic          ready;
  logic [AW-1:0] in_polar;
  logic [AW-1:0] in_azimuth;
  logic [AW-1:0] out_polar;
  logic [AW-1:0] out_azimuth;
  modport source(output valid, in_polar, in_azimuth, out_polar, out_azimuth,
                 input ready);
  modport sink(input valid, in_polar, in_azimuth, out_polar, out_azimuth,
               output ready);
endinterface

interface sm_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] m11, m12, m13, m21, m22, m23, m31, m32, m33, m44;
  modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, m44,
                 input ready);
  modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, m44,
               output ready);
endinterface

// File: src/scattering_mueller_matrix_core.sv
// Rayleigh scattering Mueller matrix core.
// req_i carries one request per handshake: incoming and outgoing polar and
// azimuth binary angles. rsp_o returns the ten non-zero matrix entries of
// that request, signed fixed point, saturated, in request order.
// cfg_we_i/cfg_wdata_i write the scattering opacity (Q4.16, reset 6554);
// write it only while no request is in flight.
// An accepted request loads the first of 31 pipelined CORDIC stages in the
// front (a load stage, then one rotation step per stage, four angles in
// parallel), passes through the four-entry queue, then passes ten
// multiply/round stages in the back.
// Throughput is one request per cycle while rsp_o is not stalled, set by
// the fully pipelined CORDIC and multiplier stages.
// When rsp_o stalls, the back holds; the queue absorbs up to four more
// requests, and the front stops and drops req_i.ready once the queue is
// full and a request waits in its last stage.
// Reset empties all pipelines and the queue and restores the opacity.
module scattering_mueller_matrix_core import sm_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [OPAC_W-1:0] cfg_wdata_i,
  sm_in_if.sink             req_i,
  sm_out_if.source          rsp_o
);

  logic [OPAC_W-1:0] opac_q;
  logic  push, pop, full, empty;
  trig_t trig_f, trig_b;

  // opacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) opac_q <= OPAC_RESET;
    else if (cfg_we_i) opac_q <= cfg_wdata_i;
  end

  sm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i, .rst_ni, .req_i, .full_i(full), .push_o(push), .trig_o(trig_f)
  );

  sm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .din_i(trig_f), .pop_i(pop),
    .dout_o(trig_b), .full_o(full), .empty_o(empty)
  );

  sm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .pop_o(pop), .trig_i(trig_b),
    .opac_i(opac_q), .rsp_o
  );

endmodule

// File: src/sm_front.sv
module sm_front import sm_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sm_in_if.sink        req_i,
  input  logic         full_i,
  output logic         push_o,
  output trig_t        trig_o
);

  logic                  v_q [STEPS+1];
  logic signed [CW-1:0]  x_q [4][STEPS+1];
  logic signed [CW-1:0]  y_q [4][STEPS+1];
  logic signed [CW-1:0]  z_q [4][STEPS+1];
  logic [1:0]            q_q [4][STEPS+1];
  logic [ANGLE_BITS-1:0] ang [4];
  logic signed [CW-1:0]  sn [4];
  logic signed [CW-1:0]  cs [4];
  logic                  adv;

  // whole front moves together unless its last stage is blocked
  assign adv         = !v_q[STEPS] || !full_i;
  assign req_i.ready = adv;
  assign push_o      = v_q[STEPS] && !full_i;

  assign ang[0] = req_i.in_polar;
  assign ang[1] = req_i.in_azimuth;
  assign ang[2] = req_i.out_polar;
  assign ang[3] = req_i.out_azimuth;

  // valid bits of the step pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STEPS; s++) v_q[s] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= req_i.valid;
      for (int s = 0; s < STEPS; s++) v_q[s+1] <= v_q[s];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [31:0] a32, a_off, zf;
    logic [1:0]  qd;

    // fold to the quadrant around zero
    assign a32   = {ang[l], {(32-ANGLE_BITS){1'b0}}};
    assign a_off = a32 + 32'h2000_0000;
    assign qd    = a_off[31:30];
    assign zf    = a32 - {qd, 30'd0};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[l][0] <= CORDIC_GAIN;
        y_q[l][0] <= '0;
        z_q[l][0] <= CW'($signed(zf));
        q_q[l][0] <= qd;
      end
    end

    // one rotation step per stage
    for (genvar s = 0; s < STEPS; s++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (adv) begin
          q_q[l][s+1] <= q_q[l][s];
          if (!z_q[l][s][CW-1]) begin
            x_q[l][s+1] <= x_q[l][s] - (y_q[l][s] >>> s);
            y_q[l][s+1] <= y_q[l][s] + (x_q[l][s] >>> s);
            z_q[l][s+1] <= z_q[l][s] - $signed(CW'(ATAN[s]));
          end else begin
            x_q[l][s+1] <= x_q[l][s] + (y_q[l][s] >>> s);
            y_q[l][s+1] <= y_q[l][s] - (x_q[l][s] >>> s);
            z_q[l][s+1] <= z_q[l][s] + $signed(CW'(ATAN[s]));
          end
        end
      end
    end

    // restore the quadrant
    always_comb begin
      case (q_q[l][STEPS])
        2'd0: begin
          cs[l] = x_q[l][STEPS];  sn[l] = y_q[l][STEPS];
        end
        2'd1: begin
          cs[l] = -y_q[l][STEPS]; sn[l] = x_q[l][STEPS];
        end
        2'd2: begin
          cs[l] = -x_q[l][STEPS]; sn[l] = -y_q[l][STEPS];
        end
        default: begin
          cs[l] = y_q[l][STEPS];  sn[l] = -x_q[l][STEPS];
        end
      endcase
    end
  end

  assign trig_o = '{sti: sn[0], cti: cs[0], spi: sn[1], cpi: cs[1],
                    sto: sn[2], cto: cs[2], spo: sn[3], cpo: cs[3]};

endmodule

// File: src/sm_queue.sv
module sm_queue import sm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  trig_t din_i,
  input  logic  pop_i,
  output trig_t dout_o,
  output logic  full_o,
  output logic  empty_o
);

  trig_t      mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

endmodule

// File: src/sm_back.sv
module sm_back import sm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  output logic              pop_o,
  input  trig_t             trig_i,
  input  logic [OPAC_W-1:0] opac_i,
  sm_out_if.source          rsp_o
);

  localparam int SH = 54 - FRAC_BITS;
  localparam int NB = 10;
  localparam logic signed [RW-1:0] LO = -(RW'(1) <<< (OUT_W-1));
  localparam logic signed [RW-1:0] HI = (RW'(1) <<< (OUT_W-1)) - 1;

  logic        vb_q [1:NB];
  logic        adv;
  trig_t       t1_q, t2_q;
  logic signed [2*CW-1:0] p1_q [4];
  logic signed [CW-1:0]   e_q [4];
  logic signed [2*CW-1:0] p3_q [9];
  logic signed [CW-1:0]   f_q [4];
  logic signed [2*CW-1:0] p5_q [10];
  logic signed [36:0]     n_q [10];
  logic signed [57:0]     o_q [10];
  logic signed [41:0]     r_q [10];
  logic signed [63:0]     k_q [10];
  logic signed [OUT_W-1:0] m_q [10];
  logic signed [RW-1:0]   s6 [10];

  assign adv         = !vb_q[NB] || rsp_o.ready;
  assign pop_o       = !empty_i && adv;
  assign rsp_o.valid = vb_q[NB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NB; s++) vb_q[s] <= 1'b0;
    end else if (adv) begin
      vb_q[1] <= pop_o;
      for (int s = 1; s < NB; s++) vb_q[s+1] <= vb_q[s];
    end
  end

  // entry sums before the final halving or plain rounding
  always_comb begin
    s6[0] = RW'(p5_q[0]) + RW'(p5_q[1]) + RW'(p5_q[2]) + RW'(p5_q[3]);
    s6[1] = RW'(p5_q[0]) - RW'(p5_q[1]) + RW'(p5_q[2]) - RW'(p5_q[3]);
    s6[2] = RW'(p5_q[4]) + RW'(p5_q[5]);
    s6[3] = RW'(p5_q[0]) + RW'(p5_q[1]) - RW'(p5_q[2]) - RW'(p5_q[3]);
    s6[4] = RW'(p5_q[0]) - RW'(p5_q[1]) - RW'(p5_q[2]) + RW'(p5_q[3]);
    s6[5] = RW'(p5_q[4]) - RW'(p5_q[5]);
    s6[6] = RW'(p5_q[6]) + RW'(p5_q[7]);
    s6[7] = RW'(p5_q[6]) - RW'(p5_q[7]);
    s6[8] = RW'(p5_q[8]) + RW'(p5_q[9]);
    s6[9] = RW'(p5_q[8]) - RW'(p5_q[9]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // direction vector products
      t1_q    <= trig_i;
      p1_q[0] <= trig_i.cti * trig_i.cpi;
      p1_q[1] <= trig_i.cti * trig_i.spi;
      p1_q[2] <= trig_i.cto * trig_i.cpo;
      p1_q[3] <= trig_i.cto * trig_i.spo;
      // round to Q30
      t2_q <= t1_q;
      for (int i = 0; i < 4; i++) e_q[i] <= CW'(rnd(RW'(p1_q[i]), 30));
      // dot product terms
      p3_q[0] <= e_q[2] * e_q[0];
      p3_q[1] <= e_q[3] * e_q[1];
      p3_q[2] <= t2_q.sto * t2_q.sti;
      p3_q[3] <= e_q[2] * t2_q.spi;
      p3_q[4] <= e_q[3] * t2_q.cpi;
      p3_q[5] <= t2_q.spo * e_q[0];
      p3_q[6] <= t2_q.cpo * e_q[1];
      p3_q[7] <= t2_q.spo * t2_q.spi;
      p3_q[8] <= t2_q.cpo * t2_q.cpi;
      // ftt, ftp, fpt, fpp
      f_q[0] <= CW'(rnd(RW'(p3_q[0]) + RW'(p3_q[1]) + RW'(p3_q[2]), 30));
      f_q[1] <= CW'(rnd(RW'(p3_q[4]) - RW'(p3_q[3]), 30));
      f_q[2] <= CW'(rnd(RW'(p3_q[6]) - RW'(p3_q[5]), 30));
      f_q[3] <= CW'(rnd(RW'(p3_q[7]) + RW'(p3_q[8]), 30));
      // squares and cross products
      p5_q[0] <= f_q[0] * f_q[0];
      p5_q[1] <= f_q[1] * f_q[1];
      p5_q[2] <= f_q[2] * f_q[2];
      p5_q[3] <= f_q[3] * f_q[3];
      p5_q[4] <= f_q[0] * f_q[1];
      p5_q[5] <= f_q[3] * f_q[2];
      p5_q[6] <= f_q[0] * f_q[2];
      p5_q[7] <= f_q[3] * f_q[1];
      p5_q[8] <= f_q[3] * f_q[0];
      p5_q[9] <= f_q[2] * f_q[1];
      // entries, then opacity and prefactor scaling
      for (int i = 0; i < 10; i++) begin
        if (i == 0 || i == 1 || i == 3 || i == 4) n_q[i] <= 37'(rnd(s6[i], 31));
        else                                      n_q[i] <= 37'(rnd(s6[i], 30));
        o_q[i] <= n_q[i] * $signed({1'b0, opac_i});
        r_q[i] <= 42'(rnd(RW'(o_q[i]), 16));
        k_q[i] <= r_q[i] * PREF_Q24;
      end
      // final rounding and saturation
      for (int i = 0; i < 10; i++) begin
        if (rnd(RW'(k_q[i]), SH) < LO)      m_q[i] <= OUT_W'(LO);
        else if (rnd(RW'(k_q[i]), SH) > HI) m_q[i] <= OUT_W'(HI);
        else                                m_q[i] <= OUT_W'(rnd(RW'(k_q[i]), SH));
      end
    end
  end

  assign rsp_o.m11 = m_q[0];
  assign rsp_o.m12 = m_q[1];
  assign rsp_o.m13 = m_q[2];
  assign rsp_o.m21 = m_q[3];
  assign rsp_o.m22 = m_q[4];
  assign rsp_o.m23 = m_q[5];
  assign rsp_o.m31 = m_q[6];
  assign rsp_o.m32 = m_q[7];
  assign rsp_o.m33 = m_q[8];
  assign rsp_o.m44 = m_q[9];

endmodule

// File: src/sm_chk.sv
module sm_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] out_m11
);

  // a stalled response stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_m11))
    else $error("response dropped or changed under stall");

  // pipeline is empty while and right after reset
  a_rst: assert property (@(posedge clk_i) $past(!rst_ni) |-> !out_valid)
    else $error("response right after reset");

  // with the back moving, the front can always take a request
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid && $past(!out_valid) |-> in_ready)
    else $error("request blocked while output drains");

endmodule

bind scattering_mueller_matrix_core sm_chk u_sm_chk (
  .clk_i, .rst_ni, .in_ready(req_i.ready), .out_valid(rsp_o.valid),
  .out_ready(rsp_o.ready), .out_m11(rsp_o.m11)
);
